/* rtl/wom_pkg.sv */
package wom_pkg;

    localparam int TIME_W      = 32;
    localparam int TEMP_W      = 12;
    localparam int TEMP_MAG_W  = 10;
    localparam int DEG_W       = 8;
    localparam int COUNT_OUT_W = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    localparam logic signed [TEMP_W-1:0] FAIL_LEVEL = 12'sd672;
    localparam logic signed [TEMP_W-1:0] TEMP_LOW   = 12'sd160;
    localparam logic signed [TEMP_W-1:0] TEMP_HIGH  = 12'sd960;

    localparam logic signed [TEMP_W-1:0] WARN_RESET   = 12'sd656;
    localparam logic [TIME_W-1:0]        PERIOD_RESET = 32'd300;
    localparam logic [COUNT_OUT_W-1:0]   MIN_RESET    = 7'd10;

    localparam logic OP_TICK   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WARN   = 2'd0,
        REG_PERIOD = 2'd1,
        REG_MIN    = 2'd2
    } cfg_reg_t;

    typedef enum logic [1:0] {
        KIND_NONE    = 2'd0,
        KIND_CORRUPT = 2'd1,
        KIND_TEMP    = 2'd2
    } sample_kind_t;

    typedef enum logic [1:0] {
        RPT_TICK    = 2'd0,
        RPT_NODATA  = 2'd1,
        RPT_CORRUPT = 2'd2,
        RPT_TEMP    = 2'd3
    } report_kind_t;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] stamp;
        logic [TEMP_W-1:0] temp;
    } hist_entry_t;

endpackage

/* rtl/wom_hist.sv */
module wom_hist
    import wom_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)(
    input  logic        clk,
    input  logic        we,
    input  logic [AW-1:0] waddr,
    input  hist_entry_t wdata,
    input  logic        re,
    input  logic [AW-1:0] raddr,
    output hist_entry_t rdata
);

    hist_entry_t mem [DEPTH];
    hist_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/wom_div.sv */
module wom_div
    import wom_pkg::*;
#(
    parameter int NUM_W = 16,
    parameter int DEN_W = 7
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             busy,
    output logic             done,
    output logic [NUM_W-1:0] quot
);

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  num_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DEN_W:0]    rem_shift;
    logic              q_bit;
    logic [DEN_W:0]    rem_diff;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[NUM_W-1]};
        q_bit     = rem_shift >= {1'b0, den_reg};
        rem_diff  = q_bit ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg  <= '0;
            den_reg  <= '0;
            rem_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                num_reg  <= num;
                den_reg  <= den;
                rem_reg  <= '0;
                step_reg <= STEP_W'(NUM_W);
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                num_reg  <= {num_reg[NUM_W-2:0], q_bit};
                rem_reg  <= rem_diff[DEN_W-1:0];
                step_reg <= step_reg - 1'b1;
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = num_reg;

endmodule

/* rtl/windowed_average_overtemp_monitor_top.sv */
// Over-temperature monitor with a time-windowed moving average over a ring of DEPTH
// samples. Ticks and samples that are not stored pass through ST_DONE to the registered
// output, and s_tready returns in the same cycle as that result is presented. A stored
// reading passes through one history write, one sweep of the history memory at one entry
// per cycle to expire old entries and sum the rest, a bit-serial divide of the sum by the
// count (skipped when the window is empty), a decision state and an output state.
// When a valid average is lost, a clearing pass over every history entry follows before
// the result. A result held by m_tready low holds the block until it is taken. After
// reset the history is cleared the same way, with s_tready low; configuration writes are
// taken at any time.
module windowed_average_overtemp_monitor_top
    import wom_pkg::*;
#(
    parameter int DEPTH = 64
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // time_now[31:0], temperature[43:32], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // opcode[0], sample_kind[2:1]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // reported_degrees[7:0], average[19:8],
                                             // sample_count[26:20], average_valid[27],
                                             // overtemp_warning[28], overheat_fault[29]
    output logic [M_TUSER_W-1:0]  m_tuser,   // report_kind[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = TEMP_MAG_W + IDX_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_SWEEP,
        ST_DIV,
        ST_DECIDE,
        ST_DONE
    } state_t;

    state_t state_reg;

    logic signed [TEMP_W-1:0] warn_reg;
    logic [TIME_W-1:0]        period_reg;
    logic [COUNT_OUT_W-1:0]   min_reg;

    logic [TIME_W-1:0]        clock_now_reg;
    logic [IDX_W-1:0]         slot_reg;
    logic signed [TEMP_W-1:0] avg_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     mean_ok_reg;

    logic                     op_reg;
    logic [1:0]               kind_reg;
    logic signed [TEMP_W-1:0] temp_reg;

    logic [CNT_W-1:0]         cnt_reg;
    logic                     pend_reg;
    logic [IDX_W-1:0]         pend_addr_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic                     report_reg;

    logic                     m_tvalid_reg;
    logic [M_TDATA_W-1:0]     m_tdata_reg;
    logic [M_TUSER_W-1:0]     m_tuser_reg;

    hist_entry_t              entry;
    hist_entry_t              hist_wdata;
    hist_entry_t              hist_rdata_w;
    logic                     hist_we;
    logic [IDX_W-1:0]         hist_waddr;
    logic                     hist_re;
    logic [IDX_W-1:0]         hist_raddr;

    logic                     div_start;
    logic                     div_busy;
    logic                     div_done;
    logic [SUM_W-1:0]         div_quot;

    logic                     issue;
    logic [TIME_W-1:0]        age;
    logic                     expire;
    logic                     keep;

    logic                     in_tick;
    logic [1:0]               in_kind;
    logic signed [TEMP_W-1:0] in_temp;
    logic                     in_store;

    logic signed [TEMP_W:0]   deg_adj;
    logic [1:0]               rpt_kind;
    logic signed [DEG_W-1:0]  rpt_deg;
    logic                     rpt_fail;
    logic                     rpt_warn;
    logic                     out_free;
    logic signed [TEMP_W-1:0] mean;
    logic [31:0]              count_ext;

    assign in_tick  = (s_tuser[0] == OP_TICK);
    assign in_kind  = s_tuser[2:1];
    assign in_temp  = s_tdata[43:32];
    assign in_store = !in_tick && (in_kind == KIND_TEMP)
                      && (in_temp >= TEMP_LOW) && (in_temp <= TEMP_HIGH);

    assign entry  = hist_entry_t'(hist_rdata_w);

    assign issue  = (state_reg == ST_SWEEP) && (cnt_reg < CNT_W'(DEPTH));
    assign age    = clock_now_reg - entry.stamp;
    assign expire = pend_reg && entry.valid && (clock_now_reg > entry.stamp)
                    && (age > period_reg);
    assign keep   = pend_reg && entry.valid && !expire;

    always_comb
    begin
        hist_we    = 1'b0;
        hist_waddr = pend_addr_reg;
        hist_wdata = '{valid: 1'b0, stamp: entry.stamp, temp: entry.temp};
        unique case (state_reg)
            ST_CLEAR:
            begin
                hist_we    = 1'b1;
                hist_waddr = cnt_reg[IDX_W-1:0];
                hist_wdata = '0;
            end
            ST_WRITE:
            begin
                hist_we    = 1'b1;
                hist_waddr = slot_reg;
                hist_wdata = '{valid: 1'b1, stamp: clock_now_reg, temp: temp_reg};
            end
            ST_SWEEP:
            begin
                hist_we = expire;
            end
            default:
            begin
                hist_we = 1'b0;
            end
        endcase
    end

    assign hist_re    = issue;
    assign hist_raddr = cnt_reg[IDX_W-1:0];

    wom_hist #(
        .DEPTH (DEPTH),
        .AW    (IDX_W)
    ) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_waddr),
        .wdata (hist_wdata),
        .re    (hist_re),
        .raddr (hist_raddr),
        .rdata (hist_rdata_w)
    );

    assign div_start = (state_reg == ST_SWEEP) && !issue && !pend_reg && (count_reg != '0);

    wom_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (sum_reg),
        .den   (count_reg),
        .busy  (div_busy),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign mean      = (count_reg == '0) ? '0 : TEMP_W'(div_quot);
    assign count_ext = 32'(count_reg);

    always_comb
    begin
        deg_adj  = {temp_reg[TEMP_W-1], temp_reg}
                   + (temp_reg[TEMP_W-1] ? (TEMP_W+1)'(15) : '0);
        rpt_fail = (op_reg == OP_TICK) && (avg_reg >= FAIL_LEVEL);
        rpt_warn = (op_reg == OP_TICK) && !rpt_fail && (avg_reg >= warn_reg);
        rpt_deg  = '0;
        if (op_reg == OP_TICK)
        begin
            rpt_kind = RPT_TICK;
        end
        else
        begin
            case (kind_reg)
                KIND_TEMP:
                begin
                    rpt_kind = RPT_TEMP;
                    rpt_deg  = deg_adj[TEMP_W-1:4];
                end
                KIND_CORRUPT:
                begin
                    rpt_kind = RPT_CORRUPT;
                end
                default:
                begin
                    rpt_kind = RPT_NODATA;
                end
            endcase
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            warn_reg      <= WARN_RESET;
            period_reg    <= PERIOD_RESET;
            min_reg       <= MIN_RESET;
            clock_now_reg <= '0;
            slot_reg      <= '0;
            avg_reg       <= '0;
            count_reg     <= '0;
            mean_ok_reg   <= 1'b0;
            op_reg        <= OP_TICK;
            kind_reg      <= '0;
            temp_reg      <= '0;
            cnt_reg       <= '0;
            pend_reg      <= 1'b0;
            pend_addr_reg <= '0;
            sum_reg       <= '0;
            report_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
            m_tuser_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WARN:   warn_reg   <= cfg_data[TEMP_W-1:0];
                    REG_PERIOD: period_reg <= cfg_data[TIME_W-1:0];
                    REG_MIN:    min_reg    <= cfg_data[COUNT_OUT_W-1:0];
                    default:    ;
                endcase
            end

            if (m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_CLEAR:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(DEPTH - 1))
                    begin
                        state_reg <= report_reg ? ST_DONE : ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg   <= s_tuser[0];
                        kind_reg <= in_kind;
                        temp_reg <= in_temp;
                        if (in_tick)
                        begin
                            clock_now_reg <= s_tdata[TIME_W-1:0];
                        end
                        state_reg <= in_store ? ST_WRITE : ST_DONE;
                    end
                end
                ST_WRITE:
                begin
                    slot_reg  <= (slot_reg == IDX_W'(DEPTH - 1)) ? '0 : slot_reg + 1'b1;
                    cnt_reg   <= '0;
                    pend_reg  <= 1'b0;
                    sum_reg   <= '0;
                    count_reg <= '0;
                    state_reg <= ST_SWEEP;
                end
                ST_SWEEP:
                begin
                    pend_reg      <= issue;
                    pend_addr_reg <= cnt_reg[IDX_W-1:0];
                    if (issue)
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                    if (keep)
                    begin
                        sum_reg   <= sum_reg + SUM_W'(entry.temp[TEMP_MAG_W-1:0]);
                        count_reg <= count_reg + 1'b1;
                    end
                    if (!issue && !pend_reg)
                    begin
                        state_reg <= (count_reg != '0) ? ST_DIV : ST_DECIDE;
                    end
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    if (count_ext >= 32'(min_reg))
                    begin
                        mean_ok_reg <= 1'b1;
                        avg_reg     <= mean;
                        state_reg   <= ST_DONE;
                    end
                    else if (mean_ok_reg)
                    begin
                        slot_reg    <= '0;
                        avg_reg     <= '0;
                        count_reg   <= '0;
                        mean_ok_reg <= 1'b0;
                        cnt_reg     <= '0;
                        report_reg  <= 1'b1;
                        state_reg   <= ST_CLEAR;
                    end
                    else
                    begin
                        avg_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tuser_reg  <= rpt_kind;
                        m_tdata_reg  <= {2'b00, rpt_fail, rpt_warn, mean_ok_reg,
                                         count_ext[COUNT_OUT_W-1:0], avg_reg, rpt_deg};
                        report_reg   <= 1'b0;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_avg_zero_when_invalid: assert property (@(posedge clk) disable iff (!rst_n)
        !mean_ok_reg |-> (avg_reg == '0))
        else $error("average nonzero while mean is invalid");

    a_avg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        mean_ok_reg |-> (avg_reg >= 0) && (avg_reg <= TEMP_HIGH))
        else $error("average outside stored temperature range");

    a_alarm_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[28] && m_tdata[29]))
        else $error("warning and failure raised together");

    a_alarm_tick_only: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser != RPT_TICK)) |-> (!m_tdata[28] && !m_tdata[29]))
        else $error("alarm raised on a non-tick result");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("valid count exceeds history depth");

endmodule

/* dv/wom_checker.sv */
module wom_checker
    import wom_pkg::*;
#(
    parameter int DEPTH = 64
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // time_now[31:0], temperature[43:32], zero pad
    input  logic [S_TUSER_W-1:0]  s_tuser,   // opcode[0], sample_kind[2:1]
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,   // reported_degrees[7:0], average[19:8],
                                             // sample_count[26:20], average_valid[27],
                                             // overtemp_warning[28], overheat_fault[29]
    input  logic [M_TUSER_W-1:0]  m_tuser,   // report_kind[1:0]
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        report_kind_t                   kind;
        logic signed [DEG_W-1:0]        degrees;
        logic signed [TEMP_W-1:0]       average;
        logic [COUNT_OUT_W-1:0]         count;
        logic                           avg_ok;
        logic                           warn;
        logic                           fail;
    } report_t;

    report_t reports_due[$];

    logic signed [TEMP_W-1:0] ring_temp  [DEPTH];
    logic [TIME_W-1:0]        ring_stamp [DEPTH];
    logic                     ring_live  [DEPTH];
    int                       slot;
    int                       mean_now;
    int                       live_count;
    logic                     mean_held;
    logic [TIME_W-1:0]        now_s;

    logic signed [TEMP_W-1:0] warn_level;
    logic [TIME_W-1:0]        period;
    logic [COUNT_OUT_W-1:0]   min_live;

    function automatic void wipe_history();
        for (int i = 0; i < DEPTH; i++)
        begin
            ring_temp[i]  = '0;
            ring_stamp[i] = '0;
            ring_live[i]  = 1'b0;
        end
        slot       = 0;
        mean_now   = 0;
        live_count = 0;
        mean_held  = 1'b0;
    endfunction

    function automatic void store_reading(int t);
        int sum;
        int mean;
        sum  = 0;
        mean = 0;
        ring_temp[slot]  = t[TEMP_W-1:0];
        ring_stamp[slot] = now_s;
        ring_live[slot]  = 1'b1;
        slot = (slot + 1 >= DEPTH) ? 0 : slot + 1;
        // age out entries strictly older than the window
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ring_live[i] && now_s > ring_stamp[i] && (now_s - ring_stamp[i]) > period)
                ring_live[i] = 1'b0;
        end
        live_count = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (ring_live[i])
            begin
                sum += int'(ring_temp[i]);
                live_count++;
            end
        end
        if (live_count > 0)
            mean = sum / live_count;
        if (live_count >= int'(min_live))
            mean_held = 1'b1;
        else if (mean_held)
            wipe_history();
        mean_now = mean_held ? mean : 0;
    endfunction

    function automatic report_t predict_report(logic [S_TDATA_W-1:0] d,
                                               logic [S_TUSER_W-1:0] u);
        report_t    r;
        int         t;
        logic [1:0] kind;
        r.kind    = RPT_TICK;
        r.degrees = '0;
        r.warn    = 1'b0;
        r.fail    = 1'b0;
        kind      = u[2:1];
        if (u[0] == OP_TICK)
        begin
            now_s = d[31:0];
            if (mean_now >= int'(FAIL_LEVEL))
                r.fail = 1'b1;
            else if (mean_now >= int'(warn_level))
                r.warn = 1'b1;
        end
        else if (kind == KIND_TEMP)
        begin
            t         = int'($signed(d[43:32]));
            r.kind    = RPT_TEMP;
            r.degrees = DEG_W'(t / 16);
            if (t >= int'(TEMP_LOW) && t <= int'(TEMP_HIGH))
                store_reading(t);
        end
        else if (kind == KIND_CORRUPT)
            r.kind = RPT_CORRUPT;
        else
            r.kind = RPT_NODATA;
        r.average = mean_now[TEMP_W-1:0];
        r.count   = live_count[COUNT_OUT_W-1:0];
        r.avg_ok  = mean_held;
        return r;
    endfunction

    function automatic void compare(string field, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        report_t due;
        if (!rst_n)
        begin
            wipe_history();
            now_s      = '0;
            warn_level = WARN_RESET;
            period     = PERIOD_RESET;
            min_live   = MIN_RESET;
            reports_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (reports_due.size() == 0)
                begin
                    $error("result transfer with no report pending");
                    mismatches++;
                end
                else
                begin
                    due = reports_due.pop_front();
                    compare("report_kind", int'(due.kind), int'(m_tuser[1:0]));
                    compare("reported_degrees", int'(due.degrees),
                            int'($signed(m_tdata[7:0])));
                    compare("average", int'(due.average), int'($signed(m_tdata[19:8])));
                    compare("sample_count", int'(due.count), int'(m_tdata[26:20]));
                    compare("average_valid", int'(due.avg_ok), int'(m_tdata[27]));
                    compare("overtemp_warning", int'(due.warn), int'(m_tdata[28]));
                    compare("overheat_fault", int'(due.fail), int'(m_tdata[29]));
                end
            end
            if (s_tvalid && s_tready)
                reports_due.push_back(predict_report(s_tdata, s_tuser));
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_WARN:   warn_level = cfg_data[TEMP_W-1:0];
                    REG_PERIOD: period     = cfg_data[TIME_W-1:0];
                    REG_MIN:    min_live   = cfg_data[COUNT_OUT_W-1:0];
                    default:    ;
                endcase
            end
        end
        outstanding = reports_due.size();
    end

endmodule

/* dv/tb_top.sv */
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wom_pkg::*;

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 72;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic [M_TUSER_W-1:0]  m_tuser;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int                    mismatches;
    int                    outstanding;
    int                    stall_cycles = 0;
    bit                    sender_calm  = 1'b0;
    bit                    sink_calm    = 1'b0;
    logic [TIME_W-1:0]     clock_s      = '0;

    windowed_average_overtemp_monitor_top #(.DEPTH(DEPTH)) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    wom_checker #(.DEPTH(DEPTH)) u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic int idle_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 80);
    endfunction

    initial
    begin : sink
        int gap;
        forever
        begin
            @(negedge clk);
            m_tready = 1'b1;
            repeat ($urandom_range(0, 20)) @(negedge clk);
            gap = idle_gap(sink_calm);
            if (gap > 0)
            begin
                m_tready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    end

    // call and return at a falling edge; s_tvalid stays high when no gap follows
    task automatic send_item(input logic op, input logic [TIME_W-1:0] stamp,
                             input logic [1:0] kind, input logic [TEMP_W-1:0] temp);
        int gap;
        s_tdata  = {4'b0, temp, stamp};
        s_tuser  = {kind, op};
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        gap = idle_gap(sender_calm);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    task automatic write_regs(input logic [TEMP_W-1:0] warn, input logic [TIME_W-1:0] period,
                              input logic [COUNT_OUT_W-1:0] min_count);
        cfg_we    = 1'b1;
        cfg_index = REG_WARN;
        cfg_data  = CFG_DATA_W'(warn);
        @(negedge clk);
        cfg_index = REG_PERIOD;
        cfg_data  = period;
        @(negedge clk);
        cfg_index = REG_MIN;
        cfg_data  = CFG_DATA_W'(min_count);
        @(negedge clk);
        cfg_we    = 1'b0;
    endtask

    task automatic random_item();
        int                r;
        int                step;
        logic [TEMP_W-1:0] temp;
        logic [TIME_W-1:0] junk;
        logic [1:0]        kind;
        r    = $urandom_range(0, 99);
        temp = TEMP_W'($urandom);
        junk = $urandom;
        kind = 2'($urandom);
        if (r < 25)
        begin
            step = $urandom_range(0, 99);
            if (step < 4)
                clock_s = $urandom;
            else if (step < 8)
                clock_s = clock_s - $urandom_range(1, 200);
            else if (step < 10)
                clock_s = '1;
            else
                clock_s = clock_s + $urandom_range(0, 25);
            send_item(OP_TICK, clock_s, kind, temp);
        end
        else if (r < 85)
        begin
            temp = (r < 70) ? TEMP_W'($urandom_range(600, 760))
                            : TEMP_W'($urandom_range(160, 960));
            send_item(OP_SAMPLE, junk, KIND_TEMP, temp);
        end
        else if (r < 92)
            send_item(OP_SAMPLE, junk, KIND_TEMP, temp);
        else
        begin
            kind = 2'($urandom_range(0, 2));
            if (kind == KIND_TEMP)
                kind = KIND_SPARE;
            send_item(OP_SAMPLE, junk, kind, temp);
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings: empty window, reports that store nothing, range edges
        send_item(OP_TICK, '0, KIND_NONE, '0);
        send_item(OP_SAMPLE, '1, KIND_NONE, 12'sd700);
        send_item(OP_SAMPLE, '0, KIND_CORRUPT, 12'sd700);
        send_item(OP_SAMPLE, '0, KIND_SPARE, 12'sd700);
        send_item(OP_SAMPLE, '0, KIND_TEMP, 12'h800);
        send_item(OP_SAMPLE, '0, KIND_TEMP, 12'h7FF);
        send_item(OP_SAMPLE, '0, KIND_TEMP, -12'sd17);
        send_item(OP_SAMPLE, '0, KIND_TEMP, 12'sd159);
        send_item(OP_SAMPLE, '0, KIND_TEMP, 12'sd961);
        send_item(OP_SAMPLE, '0, KIND_TEMP, TEMP_LOW);
        send_item(OP_SAMPLE, '0, KIND_TEMP, TEMP_HIGH);
        // fill to the minimum count with a mean of exactly 42 degrees
        repeat (8) send_item(OP_SAMPLE, '0, KIND_TEMP, 12'sd700);
        send_item(OP_TICK, '0, KIND_TEMP, 12'h5A5);
        // jump past the window: the next stored reading loses the mean
        send_item(OP_TICK, 32'd400, KIND_NONE, '0);
        send_item(OP_SAMPLE, '0, KIND_TEMP, 12'sd700);
        send_item(OP_TICK, '0, KIND_NONE, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            case (p)
                0: write_regs(TEMP_W'($urandom_range(640, 700)), PERIOD_RESET, MIN_RESET);
                1: write_regs(12'h800, '0, '0);
                2: write_regs(12'h7FF, '1, 7'd64);
                3: write_regs(TEMP_W'($urandom_range(600, 720)), $urandom_range(20, 200),
                              7'h7F);
                4: write_regs(TEMP_W'($urandom_range(600, 720)), $urandom_range(50, 400),
                              7'd1);
                5: write_regs(TEMP_W'($urandom), $urandom,
                              COUNT_OUT_W'($urandom_range(0, 64)));
                6: write_regs(WARN_RESET, PERIOD_RESET, MIN_RESET);
                default: write_regs(TEMP_W'($urandom_range(620, 700)),
                                    $urandom_range(100, 1000),
                                    COUNT_OUT_W'($urandom_range(2, 20)));
            endcase
            sender_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            repeat (PHASE_ITEMS) random_item();
        end

        drain();
        repeat (4 * DEPTH) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
